FILE: rtl/trt_pkg.sv
// Shared types, codes and default sizes for the thin block remap translator.
// No dependencies.
package trt_pkg;

  localparam int PARTITIONS_DEF    = 4;
  localparam int EXTENTS_DEF       = 8;
  localparam int MAPPED_BLOCKS_DEF = 4096;
  localparam int MAX_CHUNKS_DEF    = 64;

  localparam int BLK_W       = 20;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_PART = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_TOO_MANY = 2'd3;

  localparam logic [1:0] CFG_BLOCK_SIZE = 2'd0;
  localparam logic [1:0] CFG_PART_COUNT = 2'd1;
  localparam logic [1:0] CFG_FIRST_FREE = 2'd2;

  localparam logic [16:0] BS_MIN = 17'd512;
  localparam logic [16:0] BS_MAX = 17'd65536;

  typedef struct packed {
    logic [16:0] bs;
    logic [2:0]  pcount;
  } cfg_t;

  typedef struct packed {
    logic             plain;
    logic [1:0]       status;
    logic             wr;
    logic             last;
    logic [BLK_W-1:0] blk;
    logic [15:0]      inoff;
    logic [16:0]      clen;
  } desc_t;

  typedef struct packed {
    logic [39:0] phys;
    logic [16:0] clen;
    logic        zf;
    logic        alloc;
    logic [1:0]  status;
    logic        last;
  } res_t;

endpackage

FILE: rtl/trt_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module trt_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/trt_fifo.sv
// Small flop-based word queue with push/pop and full/empty flags.
// No dependencies.
module trt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, rp_r;
  logic [CNW-1:0]   cnt_r;
  logic             do_push, do_pop;

  assign full    = (int'(cnt_r) == DEPTH);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (int'(wp_r) == DEPTH - 1) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (int'(rp_r) == DEPTH - 1) ? '0 : rp_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end
endmodule

FILE: rtl/trt_front.sv
// Front end: accepts words, holds the extent tables, checks and divides,
// walks the extents and issues chunk descriptors. Depends on trt_pkg.
module trt_front #(
  parameter int PARTITIONS    = trt_pkg::PARTITIONS_DEF,
  parameter int EXTENTS       = trt_pkg::EXTENTS_DEF,
  parameter int MAPPED_BLOCKS = trt_pkg::MAPPED_BLOCKS_DEF,
  parameter int MAX_CHUNKS    = trt_pkg::MAX_CHUNKS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  trt_pkg::cfg_t cfg,
  input  logic          hold,
  input  logic          in_push,
  output logic          in_full,
  input  logic [1:0]    in_cmd,
  input  logic [1:0]    in_partition,
  input  logic [39:0]   in_offset,
  input  logic [20:0]   in_size,
  input  logic [2:0]    in_extent_index,
  input  logic [23:0]   in_extent_start,
  input  logic [24:0]   in_extent_length,
  output logic          q_push,
  output trt_pkg::desc_t q_din,
  input  logic          q_full
);
  import trt_pkg::*;

  localparam int SLOTS = PARTITIONS * EXTENTS;
  localparam int SLW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SW    = (EXTENTS > 1) ? $clog2(EXTENTS) : 1;
  localparam int TOT_W = $clog2(EXTENTS) + 25;
  localparam int PW    = TOT_W + 17;
  localparam int CW    = $clog2(MAX_CHUNKS + 2);

  typedef enum logic [3:0] {
    F_IDLE, F_CHECK, F_SUM, F_PROD, F_RANGE, F_DIV, F_WALK, F_STEP, F_SKIP, F_PLAIN
  } fstate_t;

  fstate_t          state_r;
  logic [23:0]      ext_st_r  [SLOTS];
  logic [24:0]      ext_len_r [SLOTS];
  logic             wr_r, first_r, bad_r, emit_r;
  logic [1:0]       part_r, status_r;
  logic [39:0]      off_r, quo_r;
  logic [20:0]      size_r, remain_r;
  logic [TOT_W-1:0] tot_r, rel_r, rel0_r;
  logic [SW-1:0]    s_r, s0_r;
  logic [PW-1:0]    prod_r;
  logic [16:0]      rem_r;
  logic [5:0]       bit_r;
  logic [CW-1:0]    cnt_r;

  logic             acc, load_ok;
  logic [SLW-1:0]   cur_slot, load_slot;
  logic [23:0]      cur_st;
  logic [24:0]      cur_len;
  logic [25:0]      r_big;
  logic             blk_bad, seg_end, is_last, too_many, range_bad, ge, bad_part;
  logic [16:0]      inoff, avail, clen, rem_sub;
  logic [20:0]      rem_after;
  logic [TOT_W-1:0] rel_inc;
  logic [17:0]      rem_sh;
  logic [40:0]      end_w;
  logic [CW-1:0]    cnt_inc;
  logic [39:0]      quo_nxt;

  assign in_full   = (state_r != F_IDLE) || hold || !rst_n;
  assign acc       = in_push && !in_full;
  assign load_ok   = (int'(in_partition) < PARTITIONS) && (int'(in_extent_index) < EXTENTS);
  assign load_slot = SLW'(int'(in_partition) * EXTENTS + int'(in_extent_index));
  assign cur_slot  = SLW'(int'(part_r) * EXTENTS + int'(s_r));
  assign cur_st    = ext_st_r[cur_slot];
  assign cur_len   = ext_len_r[cur_slot];

  always_comb begin
    bad_part  = (int'(part_r) >= int'(cfg.pcount)) || (int'(part_r) >= PARTITIONS);
    r_big     = 26'(cur_st) + 26'(rel_r);
    blk_bad   = r_big >= 26'(MAPPED_BLOCKS);
    inoff     = first_r ? rem_r : 17'd0;
    avail     = cfg.bs - inoff;
    clen      = (remain_r < 21'(avail)) ? 17'(remain_r) : avail;
    rem_after = remain_r - 21'(clen);
    is_last   = (rem_after == '0);
    rel_inc   = rel_r + 1'b1;
    seg_end   = (rel_inc == TOT_W'(cur_len));
    cnt_inc   = cnt_r + 1'b1;
    too_many  = int'(cnt_inc) > MAX_CHUNKS;
    end_w     = {1'b0, off_r} + 41'(size_r);
    range_bad = PW'(end_w) > prod_r;
    rem_sh    = {rem_r, quo_r[39]};
    ge        = rem_sh >= {1'b0, cfg.bs};
    rem_sub   = 17'(rem_sh - {1'b0, cfg.bs});
    quo_nxt   = {quo_r[38:0], ge};
  end

  always_comb begin
    q_din.plain  = (state_r == F_PLAIN);
    q_din.status = (state_r == F_PLAIN) ? status_r : ST_OK;
    q_din.wr     = wr_r;
    q_din.last   = (state_r == F_PLAIN) ? 1'b1 : is_last;
    q_din.blk    = BLK_W'(r_big);
    q_din.inoff  = 16'(inoff);
    q_din.clen   = clen;
    q_push       = !q_full && ((state_r == F_PLAIN) || (state_r == F_STEP && emit_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        ext_st_r[i]  <= '0;
        ext_len_r[i] <= '0;
      end
    end else if (acc && in_cmd == CMD_LOAD && load_ok) begin
      ext_st_r[load_slot]  <= in_extent_start;
      ext_len_r[load_slot] <= in_extent_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (acc && (in_cmd == CMD_READ || in_cmd == CMD_WRITE)) begin
            state_r <= F_CHECK;
          end
        end
        F_CHECK: begin
          if (bad_part) begin
            status_r <= ST_BAD_PART;
            state_r  <= F_PLAIN;
          end else if (size_r == '0) begin
            status_r <= ST_OK;
            state_r  <= F_PLAIN;
          end else begin
            s_r     <= '0;
            tot_r   <= '0;
            state_r <= F_SUM;
          end
        end
        F_SUM: begin
          tot_r <= tot_r + TOT_W'(cur_len);
          if (int'(s_r) == EXTENTS - 1) begin
            state_r <= F_PROD;
          end else begin
            s_r <= s_r + 1'b1;
          end
        end
        F_PROD: begin
          prod_r  <= PW'(tot_r) * PW'(cfg.bs);
          state_r <= F_RANGE;
        end
        F_RANGE: begin
          if (range_bad) begin
            status_r <= ST_RANGE;
            state_r  <= F_PLAIN;
          end else begin
            quo_r   <= off_r;
            rem_r   <= '0;
            bit_r   <= '0;
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          quo_r <= quo_nxt;
          rem_r <= ge ? rem_sub : rem_sh[16:0];
          bit_r <= bit_r + 1'b1;
          if (bit_r == 6'd39) begin
            s_r     <= '0;
            rel_r   <= TOT_W'(quo_nxt);
            state_r <= F_WALK;
          end
        end
        F_WALK: begin
          if (rel_r < TOT_W'(cur_len)) begin
            s0_r     <= s_r;
            rel0_r   <= rel_r;
            remain_r <= size_r;
            first_r  <= 1'b1;
            cnt_r    <= '0;
            bad_r    <= 1'b0;
            emit_r   <= 1'b0;
            state_r  <= F_STEP;
          end else begin
            rel_r <= rel_r - TOT_W'(cur_len);
            s_r   <= s_r + 1'b1;
          end
        end
        F_STEP: begin
          if (!emit_r) begin
            cnt_r <= cnt_inc;
            bad_r <= bad_r || blk_bad;
            if (too_many) begin
              status_r <= ST_TOO_MANY;
              state_r  <= F_PLAIN;
            end else if (is_last) begin
              if (bad_r || blk_bad) begin
                status_r <= ST_RANGE;
                state_r  <= F_PLAIN;
              end else begin
                s_r      <= s0_r;
                rel_r    <= rel0_r;
                remain_r <= size_r;
                first_r  <= 1'b1;
                emit_r   <= 1'b1;
              end
            end else begin
              first_r  <= 1'b0;
              remain_r <= rem_after;
              if (seg_end) begin
                s_r     <= s_r + 1'b1;
                rel_r   <= '0;
                state_r <= F_SKIP;
              end else begin
                rel_r <= rel_inc;
              end
            end
          end else if (!q_full) begin
            if (is_last) begin
              state_r <= F_IDLE;
            end else begin
              first_r  <= 1'b0;
              remain_r <= rem_after;
              if (seg_end) begin
                s_r     <= s_r + 1'b1;
                rel_r   <= '0;
                state_r <= F_SKIP;
              end else begin
                rel_r <= rel_inc;
              end
            end
          end
        end
        F_SKIP: begin
          if (cur_len != '0) begin
            state_r <= F_STEP;
          end else begin
            s_r <= s_r + 1'b1;
          end
        end
        F_PLAIN: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc && state_r == F_IDLE) begin
      wr_r   <= (in_cmd == CMD_WRITE);
      part_r <= in_partition;
      off_r  <= in_offset;
      size_r <= in_size;
    end
  end
endmodule

FILE: rtl/trt_back.sv
// Back end: clears the jump table after reset, looks up and allocates
// blocks, forms physical addresses. Depends on trt_pkg and trt_ram.
module trt_back #(
  parameter int MAPPED_BLOCKS = trt_pkg::MAPPED_BLOCKS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [16:0]    bs,
  input  logic           ff_load,
  input  logic [23:0]    ff_value,
  input  logic           q_empty,
  input  trt_pkg::desc_t q_dout,
  output logic           q_pop,
  input  logic           r_full,
  output logic           r_push,
  output trt_pkg::res_t  r_din,
  output logic           clearing
);
  import trt_pkg::*;

  localparam int AW = $clog2(MAPPED_BLOCKS);

  typedef enum logic [2:0] {B_CLEAR, B_IDLE, B_LOOK, B_MUL, B_PUSH} bstate_t;

  bstate_t       state_r;
  logic [AW-1:0] clr_r;
  desc_t         d_r;
  logic [23:0]   entry_r, nf_r, rdata;
  logic          zf_r, alloc_r;
  logic [39:0]   phys_r;
  logic          we;
  logic [AW-1:0] waddr;
  logic [23:0]   wdata;

  assign clearing = (state_r == B_CLEAR);
  assign q_pop    = (state_r == B_IDLE) && !q_empty;
  assign r_push   = (state_r == B_PUSH) && !r_full;

  always_comb begin
    we    = 1'b0;
    waddr = clr_r;
    wdata = '0;
    if (state_r == B_CLEAR) begin
      we = 1'b1;
    end else if (state_r == B_LOOK && d_r.wr && rdata == '0) begin
      we    = 1'b1;
      waddr = d_r.blk[AW-1:0];
      wdata = nf_r;
    end
  end

  always_comb begin
    r_din.phys   = phys_r;
    r_din.clen   = d_r.plain ? 17'd0 : d_r.clen;
    r_din.zf     = zf_r;
    r_din.alloc  = alloc_r;
    r_din.status = d_r.status;
    r_din.last   = d_r.last;
  end

  trt_ram #(.WIDTH(24), .DEPTH(MAPPED_BLOCKS)) u_jump (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (q_dout.blk[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_CLEAR;
      clr_r   <= '0;
      nf_r    <= 24'd1;
    end else begin
      if (ff_load) begin
        nf_r <= (ff_value == '0) ? 24'd1 : ff_value;
      end
      case (state_r)
        B_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (int'(clr_r) == MAPPED_BLOCKS - 1) begin
            state_r <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty) begin
            d_r     <= q_dout;
            zf_r    <= 1'b0;
            alloc_r <= 1'b0;
            phys_r  <= '0;
            state_r <= q_dout.plain ? B_PUSH : B_LOOK;
          end
        end
        B_LOOK: begin
          if (d_r.wr && rdata == '0) begin
            entry_r <= nf_r;
            alloc_r <= 1'b1;
            nf_r    <= (nf_r == 24'hFFFFFF) ? 24'd1 : nf_r + 1'b1;
          end else begin
            entry_r <= rdata;
          end
          zf_r    <= !d_r.wr && rdata == '0;
          state_r <= B_MUL;
        end
        B_MUL: begin
          phys_r  <= zf_r ? 40'd0 : 40'(41'(entry_r) * 41'(bs) + 41'(d_r.inoff));
          state_r <= B_PUSH;
        end
        B_PUSH: begin
          if (!r_full) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/thin_block_remap_translator.sv
// Top level of the thin block remap translator: configuration registers,
// front end, descriptor queue, back end and result queue. Depends on trt_pkg,
// trt_front, trt_fifo and trt_back.
// Use: push words on in_* while in_full is low; pop results on out_* while
// out_empty is low. A load word (cmd 2) writes one extent slot and returns
// nothing. A read or write word returns one result per block-bounded chunk
// (a single result for an error or zero size), last set on the final one.
// An access passes through the front end (check, extent sum, product, range
// check, 40-step restoring divider, walk over the slots), then a checking pass
// and an issue pass over the chunks that step across extent boundaries and
// skip empty slots. The back end handles each chunk in steps (jump table read,
// lookup/allocate, multiply, push). A load word does not leave the front
// end's idle state.
// After reset the jump table is cleared one entry a cycle: in_full stays
// high until all MAPPED_BLOCKS entries (4096 by default) are cleared.
// When the receiver stalls, the result queue fills, then the back end and
// the descriptor queue; the front end stops and in_full stays high.
// cfg_* writes take effect at once and are meant for idle periods.
module thin_block_remap_translator #(
  parameter int PARTITIONS    = trt_pkg::PARTITIONS_DEF,
  parameter int EXTENTS       = trt_pkg::EXTENTS_DEF,
  parameter int MAPPED_BLOCKS = trt_pkg::MAPPED_BLOCKS_DEF,
  parameter int MAX_CHUNKS    = trt_pkg::MAX_CHUNKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_cmd,
  input  logic [1:0]  in_partition,
  input  logic [39:0] in_offset,
  input  logic [20:0] in_size,
  input  logic [2:0]  in_extent_index,
  input  logic [23:0] in_extent_start,
  input  logic [24:0] in_extent_length,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [39:0] out_phys_addr,
  output logic [16:0] out_chunk_length,
  output logic        out_zero_fill,
  output logic        out_allocated,
  output logic [1:0]  out_status,
  output logic        out_last
);
  import trt_pkg::*;

  logic [16:0] block_size_r;
  logic [2:0]  pcount_r;
  cfg_t        cfg;
  logic        clearing, ff_load;
  logic        q_push, q_full, q_pop, q_empty;
  desc_t       q_din, q_dout;
  logic        r_push, r_full, r_empty;
  res_t        r_din, r_dout;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r <= 17'd4096;
      pcount_r     <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_SIZE: block_size_r <= cfg_wdata[16:0];
        CFG_PART_COUNT: pcount_r     <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (block_size_r < BS_MIN) begin
      cfg.bs = BS_MIN;
    end else if (block_size_r > BS_MAX) begin
      cfg.bs = BS_MAX;
    end else begin
      cfg.bs = block_size_r;
    end
    cfg.pcount = pcount_r;
  end

  assign ff_load = cfg_we && cfg_index == CFG_FIRST_FREE;

  trt_front #(
    .PARTITIONS(PARTITIONS), .EXTENTS(EXTENTS),
    .MAPPED_BLOCKS(MAPPED_BLOCKS), .MAX_CHUNKS(MAX_CHUNKS)
  ) u_front (
    .clk, .rst_n, .cfg, .hold(clearing),
    .in_push, .in_full, .in_cmd, .in_partition, .in_offset, .in_size,
    .in_extent_index, .in_extent_start, .in_extent_length,
    .q_push, .q_din, .q_full
  );

  trt_fifo #(.WIDTH($bits(desc_t)), .DEPTH(QUEUE_DEPTH)) u_dq (
    .clk, .rst_n, .push(q_push), .din(q_din), .full(q_full),
    .pop(q_pop), .dout(q_dout), .empty(q_empty)
  );

  trt_back #(.MAPPED_BLOCKS(MAPPED_BLOCKS)) u_back (
    .clk, .rst_n, .bs(cfg.bs), .ff_load, .ff_value(cfg_wdata),
    .q_empty, .q_dout, .q_pop, .r_full, .r_push, .r_din, .clearing
  );

  trt_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_rq (
    .clk, .rst_n, .push(r_push), .din(r_din), .full(r_full),
    .pop(out_pop), .dout(r_dout), .empty(r_empty)
  );

  assign out_empty        = r_empty || !rst_n;
  assign out_phys_addr    = r_dout.phys;
  assign out_chunk_length = r_dout.clen;
  assign out_zero_fill    = r_dout.zf;
  assign out_allocated    = r_dout.alloc;
  assign out_status       = r_dout.status;
  assign out_last         = r_dout.last;

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> in_full) else $error("word accepted during table clear");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_OK) |->
      (out_last && out_phys_addr == '0 && out_chunk_length == '0 &&
       !out_zero_fill && !out_allocated))
    else $error("malformed error result");

  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_zero_fill && out_allocated))
    else $error("zero fill and allocation together");
endmodule
